// ===== hdl/rmch_pkg.sv =====
// ----------------------------------------------------------------------------
// rmch_pkg
// Shared widths, request codes and the multiply-accumulate microprogram of
// the closest-hit ray caster.
// ----------------------------------------------------------------------------
package rmch_pkg;

    localparam int MAX_V     = 4096;
    localparam int MAX_T     = 4096;
    localparam int V_AW      = 12;
    localparam int T_AW      = 12;
    localparam int CNT_W     = 13;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int ED_W      = COORD_W + 1;
    localparam int IDX_W     = 12;
    localparam int OPA_W     = 102;
    localparam int OPB_W     = 34;
    localparam int CHUNK_W   = 34;
    localparam int MUL_STEPS = OPA_W / CHUNK_W;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int CR_W      = 68;
    localparam int SC_W      = 104;
    localparam int NUMT_W    = 102;
    localparam int QUO_W     = NUMT_W + 16;
    localparam int DEN_W     = 88;
    localparam int TC_W      = 101;
    localparam int SQ_W      = 67;
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 144;

    localparam logic [CNT_W-1:0] MAX_V_CNT = CNT_W'(MAX_V);
    localparam logic [CNT_W-1:0] MAX_T_CNT = CNT_W'(MAX_T);

    // request kinds on the input tuser
    localparam logic [1:0] REQ_VTX  = 2'd0;
    localparam logic [1:0] REQ_TRI  = 2'd1;
    localparam logic [1:0] REQ_CAST = 2'd2;

    // configuration register indexes
    localparam logic REG_VCNT = 1'b0;
    localparam logic REG_TCNT = 1'b1;

    // wide operand selects
    localparam logic [3:0] A_DIR0 = 4'd0;
    localparam logic [3:0] A_DIR1 = 4'd1;
    localparam logic [3:0] A_DIR2 = 4'd2;
    localparam logic [3:0] A_REL0 = 4'd3;
    localparam logic [3:0] A_REL1 = 4'd4;
    localparam logic [3:0] A_REL2 = 4'd5;
    localparam logic [3:0] A_CRA0 = 4'd6;
    localparam logic [3:0] A_CRA1 = 4'd7;
    localparam logic [3:0] A_CRA2 = 4'd8;
    localparam logic [3:0] A_CRB0 = 4'd9;
    localparam logic [3:0] A_CRB1 = 4'd10;
    localparam logic [3:0] A_CRB2 = 4'd11;
    localparam logic [3:0] A_TC   = 4'd12;

    // narrow operand selects
    localparam logic [3:0] B_DIR0 = 4'd0;
    localparam logic [3:0] B_DIR1 = 4'd1;
    localparam logic [3:0] B_DIR2 = 4'd2;
    localparam logic [3:0] B_ED10 = 4'd3;
    localparam logic [3:0] B_ED11 = 4'd4;
    localparam logic [3:0] B_ED12 = 4'd5;
    localparam logic [3:0] B_ED20 = 4'd6;
    localparam logic [3:0] B_ED21 = 4'd7;
    localparam logic [3:0] B_ED22 = 4'd8;
    localparam logic [3:0] B_REL0 = 4'd9;
    localparam logic [3:0] B_REL1 = 4'd10;
    localparam logic [3:0] B_REL2 = 4'd11;

    // accumulator destinations
    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_CRA0 = 4'd1;
    localparam logic [3:0] D_CRA1 = 4'd2;
    localparam logic [3:0] D_CRA2 = 4'd3;
    localparam logic [3:0] D_CRB0 = 4'd4;
    localparam logic [3:0] D_CRB1 = 4'd5;
    localparam logic [3:0] D_CRB2 = 4'd6;
    localparam logic [3:0] D_DEN  = 4'd7;
    localparam logic [3:0] D_NUMU = 4'd8;
    localparam logic [3:0] D_NUMV = 4'd9;
    localparam logic [3:0] D_NUMT = 4'd10;
    localparam logic [3:0] D_HX   = 4'd11;
    localparam logic [3:0] D_HY   = 4'd12;
    localparam logic [3:0] D_HZ   = 4'd13;

    localparam logic [4:0] PC_TRI_LAST = 5'd23;
    localparam logic [4:0] PC_HIT0     = 5'd24;
    localparam logic [4:0] PC_HIT_LAST = 5'd26;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       neg;
        logic       first;
        logic [3:0] dst;
    } t_uop;

    function automatic t_uop uop_at(input logic [4:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = '{A_DIR1, B_ED22, 1'b0, 1'b1, D_NONE};
            5'd1:  u = '{A_DIR2, B_ED21, 1'b1, 1'b0, D_CRA0};
            5'd2:  u = '{A_DIR2, B_ED20, 1'b0, 1'b1, D_NONE};
            5'd3:  u = '{A_DIR0, B_ED22, 1'b1, 1'b0, D_CRA1};
            5'd4:  u = '{A_DIR0, B_ED21, 1'b0, 1'b1, D_NONE};
            5'd5:  u = '{A_DIR1, B_ED20, 1'b1, 1'b0, D_CRA2};
            5'd6:  u = '{A_CRA0, B_ED10, 1'b0, 1'b1, D_NONE};
            5'd7:  u = '{A_CRA1, B_ED11, 1'b0, 1'b0, D_NONE};
            5'd8:  u = '{A_CRA2, B_ED12, 1'b0, 1'b0, D_DEN};
            5'd9:  u = '{A_CRA0, B_REL0, 1'b0, 1'b1, D_NONE};
            5'd10: u = '{A_CRA1, B_REL1, 1'b0, 1'b0, D_NONE};
            5'd11: u = '{A_CRA2, B_REL2, 1'b0, 1'b0, D_NUMU};
            5'd12: u = '{A_REL1, B_ED12, 1'b0, 1'b1, D_NONE};
            5'd13: u = '{A_REL2, B_ED11, 1'b1, 1'b0, D_CRB0};
            5'd14: u = '{A_REL2, B_ED10, 1'b0, 1'b1, D_NONE};
            5'd15: u = '{A_REL0, B_ED12, 1'b1, 1'b0, D_CRB1};
            5'd16: u = '{A_REL0, B_ED11, 1'b0, 1'b1, D_NONE};
            5'd17: u = '{A_REL1, B_ED10, 1'b1, 1'b0, D_CRB2};
            5'd18: u = '{A_CRB0, B_DIR0, 1'b0, 1'b1, D_NONE};
            5'd19: u = '{A_CRB1, B_DIR1, 1'b0, 1'b0, D_NONE};
            5'd20: u = '{A_CRB2, B_DIR2, 1'b0, 1'b0, D_NUMV};
            5'd21: u = '{A_CRB0, B_ED20, 1'b0, 1'b1, D_NONE};
            5'd22: u = '{A_CRB1, B_ED21, 1'b0, 1'b0, D_NONE};
            5'd23: u = '{A_CRB2, B_ED22, 1'b0, 1'b0, D_NUMT};
            5'd24: u = '{A_TC,   B_DIR0, 1'b0, 1'b1, D_HX};
            5'd25: u = '{A_TC,   B_DIR1, 1'b0, 1'b1, D_HY};
            5'd26: u = '{A_TC,   B_DIR2, 1'b0, 1'b1, D_HZ};
            default: u = '{A_TC, B_DIR0, 1'b0, 1'b1, D_NONE};
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/rmch_mul.sv =====
// ----------------------------------------------------------------------------
// rmch_mul
// Signed wide-by-narrow multiplier, one 34x34 partial product per cycle.
// ----------------------------------------------------------------------------
module rmch_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [rmch_pkg::OPA_W-1:0]    i_a,
    input  logic signed [rmch_pkg::OPB_W-1:0]    i_b,
    input  logic                                 i_neg,
    output logic                                 o_done,
    output logic signed [rmch_pkg::PROD_W-1:0]   o_res
);

    logic [rmch_pkg::OPA_W-1:0]    r_am;
    logic [rmch_pkg::OPB_W-1:0]    r_bm;
    logic                          r_sgn;
    logic [rmch_pkg::PROD_W-1:0]   r_acc;
    logic [1:0]                    r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic signed [rmch_pkg::PROD_W-1:0] r_res;
    logic [2*rmch_pkg::CHUNK_W-1:0] w_pp;

    // top chunk first, accumulator shifts up one chunk per step
    assign w_pp = r_am[rmch_pkg::OPA_W-1 -: rmch_pkg::CHUNK_W] * r_bm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_am   <= i_a[rmch_pkg::OPA_W-1] ? -i_a : i_a;
                r_bm   <= i_b[rmch_pkg::OPB_W-1] ? -i_b : i_b;
                r_sgn  <= i_a[rmch_pkg::OPA_W-1] ^ i_b[rmch_pkg::OPB_W-1] ^ i_neg;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 2'(rmch_pkg::MUL_STEPS)) begin
                    r_res  <= r_sgn ? -$signed(r_acc) : $signed(r_acc);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc <= (r_acc << rmch_pkg::CHUNK_W) + rmch_pkg::PROD_W'(w_pp);
                    r_am  <= r_am << rmch_pkg::CHUNK_W;
                    r_cnt <= r_cnt + 2'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hdl/rmch_div.sv =====
// ----------------------------------------------------------------------------
// rmch_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmch_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rmch_pkg::QUO_W-1:0]      i_num,
    input  logic [rmch_pkg::DEN_W-1:0]      i_den,
    output logic                            o_done,
    output logic [rmch_pkg::QUO_W-1:0]      o_quo
);

    logic [rmch_pkg::QUO_W-1:0] r_n;
    logic [rmch_pkg::QUO_W-1:0] r_q;
    logic [rmch_pkg::DEN_W-1:0] r_den;
    logic [rmch_pkg::DEN_W-1:0] r_rem;
    logic [6:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [rmch_pkg::DEN_W:0]   w_sh;
    logic                       w_ge;

    assign w_sh = {r_rem, r_n[rmch_pkg::QUO_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? rmch_pkg::DEN_W'(w_sh - {1'b0, r_den})
                              : rmch_pkg::DEN_W'(w_sh);
                r_q   <= {r_q[rmch_pkg::QUO_W-2:0], w_ge};
                r_n   <= r_n << 1;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(rmch_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== hdl/ray_mesh_closest_hit.sv =====
// ----------------------------------------------------------------------------
// ray_mesh_closest_hit
// Closest-hit ray caster over a stored triangle mesh, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser req_type, tdata load/ray word
//  m_axis    out  m_axis_tvalid/tready    tuser hit, tdata hit point/dist/vertex
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data (counts)
//
//  A cast walks the triangles in turn: one with a corner out of range is
//  skipped, one failing the determinant or bounds tests stops after its 24
//  serial multiplies and one that passes adds a divide. On a hit, three
//  more multiplies give the hit point and each stored vertex is compared,
//  all through the single multiplier, divider and vertex memory read port.
//  Input is held off during a cast; the result register frees the sender.
//  Reset clears the counts and control only; the stores hold no reset.
// ----------------------------------------------------------------------------
module ray_mesh_closest_hit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, corner_a, corner_b, corner_c
    input  logic [199:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit_x, hit_y, hit_z, distance, nearest_vertex
    output logic [143:0] m_axis_tdata,
    // hit
    output logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [12:0]  i_cfg_data
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_TRI_RD = 5'd1;
    localparam logic [4:0] S_TRI_WT = 5'd2;
    localparam logic [4:0] S_VB     = 5'd3;
    localparam logic [4:0] S_VC     = 5'd4;
    localparam logic [4:0] S_VD     = 5'd5;
    localparam logic [4:0] S_EDGE   = 5'd6;
    localparam logic [4:0] S_MST    = 5'd7;
    localparam logic [4:0] S_MWT    = 5'd8;
    localparam logic [4:0] S_TEST   = 5'd9;
    localparam logic [4:0] S_TEST2  = 5'd10;
    localparam logic [4:0] S_DST    = 5'd11;
    localparam logic [4:0] S_DWT    = 5'd12;
    localparam logic [4:0] S_VS_RD  = 5'd13;
    localparam logic [4:0] S_VS_SQ  = 5'd14;
    localparam logic [4:0] S_VS_CMP = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;

    localparam int CW = rmch_pkg::COORD_W;
    localparam logic [rmch_pkg::QUO_W-1:0] TC_CAP = rmch_pkg::QUO_W'(1) << 100;

    // stores
    logic [3*CW-1:0]                 r_vmem [rmch_pkg::MAX_V];
    logic [3*rmch_pkg::IDX_W-1:0]    r_tmem [rmch_pkg::MAX_T];
    logic [3*CW-1:0]                 r_vrd;
    logic [3*rmch_pkg::IDX_W-1:0]    r_trd;
    logic                            w_v_re;
    logic [rmch_pkg::V_AW-1:0]       w_v_addr;
    logic                            w_t_re;

    logic [4:0]                      r_state;
    logic [rmch_pkg::CNT_W-1:0]      r_vcnt;
    logic [rmch_pkg::CNT_W-1:0]      r_tcnt;
    logic [rmch_pkg::CNT_W-1:0]      w_nv;
    logic [rmch_pkg::CNT_W-1:0]      w_nt;

    logic signed [CW-1:0]            r_org [3];
    logic signed [rmch_pkg::DIR_W-1:0] r_dir [3];
    logic signed [CW-1:0]            r_p0 [3];
    logic signed [CW-1:0]            r_p1 [3];
    logic signed [CW-1:0]            r_p2 [3];
    logic signed [rmch_pkg::ED_W-1:0] r_ed1 [3];
    logic signed [rmch_pkg::ED_W-1:0] r_ed2 [3];
    logic signed [rmch_pkg::ED_W-1:0] r_rel [3];
    logic signed [rmch_pkg::CR_W-1:0] r_cra [3];
    logic signed [rmch_pkg::CR_W-1:0] r_crb [3];
    logic signed [rmch_pkg::SC_W-1:0] r_den;
    logic signed [rmch_pkg::SC_W-1:0] r_numu;
    logic signed [rmch_pkg::SC_W-1:0] r_numv;
    logic signed [rmch_pkg::SC_W-1:0] r_numt;
    logic signed [rmch_pkg::PROD_W-1:0] r_acc;
    logic signed [CW-1:0]            r_dq [3];
    logic [rmch_pkg::IDX_W-1:0]      r_cb;
    logic [rmch_pkg::IDX_W-1:0]      r_cc;
    logic [rmch_pkg::CNT_W-1:0]      r_tri;
    logic [rmch_pkg::CNT_W-1:0]      r_vi;
    logic [4:0]                      r_pc;
    logic [1:0]                      r_k;
    logic                            r_have;
    logic [rmch_pkg::QUO_W-1:0]      r_best;
    logic [rmch_pkg::SQ_W-1:0]       r_sq;
    logic [rmch_pkg::SQ_W-1:0]       r_bestsq;
    logic [rmch_pkg::V_AW-1:0]       r_near;

    logic                            r_ovalid;
    logic                            r_ohit;
    logic [139:0]                    r_odata;

    logic                            w_in_acc;
    logic                            w_last_tri;
    logic                            w_out_free;
    rmch_pkg::t_uop                  w_uop;
    logic signed [rmch_pkg::OPA_W-1:0] w_opa;
    logic signed [rmch_pkg::OPB_W-1:0] w_opb;
    logic                            r_mstart;
    logic                            w_mdone;
    logic signed [rmch_pkg::PROD_W-1:0] w_mres;
    logic signed [rmch_pkg::PROD_W-1:0] w_accn;
    logic [rmch_pkg::TC_W-1:0]       w_tc;
    logic [1:0]                      w_hidx;
    logic signed [120:0]             w_hsum;
    logic signed [CW-1:0]            w_hsat;
    logic                            r_dstart;
    logic                            w_ddone;
    logic [rmch_pkg::QUO_W-1:0]      w_quo;
    logic signed [rmch_pkg::SC_W:0]  w_uv;
    logic signed [CW-1:0]            w_vk;
    logic signed [rmch_pkg::ED_W-1:0] w_df;
    logic signed [2*rmch_pkg::ED_W-1:0] w_dsq;
    logic [rmch_pkg::SQ_W-1:0]       w_sqn;

    assign w_nv = (r_vcnt > rmch_pkg::MAX_V_CNT) ? rmch_pkg::MAX_V_CNT : r_vcnt;
    assign w_nt = (r_tcnt > rmch_pkg::MAX_T_CNT) ? rmch_pkg::MAX_T_CNT : r_tcnt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_last_tri    = (r_tri + rmch_pkg::CNT_W'(1)) == w_nt;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    // ---- memories ----
    always_comb begin
        w_v_re   = 1'b0;
        w_v_addr = r_vi[rmch_pkg::V_AW-1:0];
        case (r_state)
            S_TRI_WT: begin
                w_v_re   = 1'b1;
                w_v_addr = r_trd[rmch_pkg::IDX_W-1:0];
            end
            S_VB: begin
                w_v_re   = 1'b1;
                w_v_addr = r_cb;
            end
            S_VC: begin
                w_v_re   = 1'b1;
                w_v_addr = r_cc;
            end
            S_VS_RD: begin
                w_v_re   = 1'b1;
                w_v_addr = r_vi[rmch_pkg::V_AW-1:0];
            end
            default: w_v_re = 1'b0;
        endcase
    end
    assign w_t_re = (r_state == S_TRI_RD);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == rmch_pkg::REQ_VTX) begin
            r_vmem[s_axis_tdata[11:0]] <= s_axis_tdata[107:12];
        end
        if (w_v_re) begin
            r_vrd <= r_vmem[w_v_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == rmch_pkg::REQ_TRI) begin
            r_tmem[s_axis_tdata[11:0]] <= s_axis_tdata[197:162];
        end
        if (w_t_re) begin
            r_trd <= r_tmem[r_tri[rmch_pkg::T_AW-1:0]];
        end
    end

    // ---- multiply-accumulate path ----
    assign w_uop = rmch_pkg::uop_at(r_pc);
    assign w_tc  = (r_best > TC_CAP) ? TC_CAP[rmch_pkg::TC_W-1:0]
                                     : r_best[rmch_pkg::TC_W-1:0];

    always_comb begin
        case (w_uop.a_sel)
            rmch_pkg::A_DIR0: w_opa = rmch_pkg::OPA_W'(r_dir[0]);
            rmch_pkg::A_DIR1: w_opa = rmch_pkg::OPA_W'(r_dir[1]);
            rmch_pkg::A_DIR2: w_opa = rmch_pkg::OPA_W'(r_dir[2]);
            rmch_pkg::A_REL0: w_opa = rmch_pkg::OPA_W'(r_rel[0]);
            rmch_pkg::A_REL1: w_opa = rmch_pkg::OPA_W'(r_rel[1]);
            rmch_pkg::A_REL2: w_opa = rmch_pkg::OPA_W'(r_rel[2]);
            rmch_pkg::A_CRA0: w_opa = rmch_pkg::OPA_W'(r_cra[0]);
            rmch_pkg::A_CRA1: w_opa = rmch_pkg::OPA_W'(r_cra[1]);
            rmch_pkg::A_CRA2: w_opa = rmch_pkg::OPA_W'(r_cra[2]);
            rmch_pkg::A_CRB0: w_opa = rmch_pkg::OPA_W'(r_crb[0]);
            rmch_pkg::A_CRB1: w_opa = rmch_pkg::OPA_W'(r_crb[1]);
            rmch_pkg::A_CRB2: w_opa = rmch_pkg::OPA_W'(r_crb[2]);
            default:          w_opa = $signed({1'b0, w_tc});
        endcase
        case (w_uop.b_sel)
            rmch_pkg::B_DIR0: w_opb = rmch_pkg::OPB_W'(r_dir[0]);
            rmch_pkg::B_DIR1: w_opb = rmch_pkg::OPB_W'(r_dir[1]);
            rmch_pkg::B_DIR2: w_opb = rmch_pkg::OPB_W'(r_dir[2]);
            rmch_pkg::B_ED10: w_opb = rmch_pkg::OPB_W'(r_ed1[0]);
            rmch_pkg::B_ED11: w_opb = rmch_pkg::OPB_W'(r_ed1[1]);
            rmch_pkg::B_ED12: w_opb = rmch_pkg::OPB_W'(r_ed1[2]);
            rmch_pkg::B_ED20: w_opb = rmch_pkg::OPB_W'(r_ed2[0]);
            rmch_pkg::B_ED21: w_opb = rmch_pkg::OPB_W'(r_ed2[1]);
            rmch_pkg::B_ED22: w_opb = rmch_pkg::OPB_W'(r_ed2[2]);
            rmch_pkg::B_REL0: w_opb = rmch_pkg::OPB_W'(r_rel[0]);
            rmch_pkg::B_REL1: w_opb = rmch_pkg::OPB_W'(r_rel[1]);
            default:          w_opb = rmch_pkg::OPB_W'(r_rel[2]);
        endcase
    end

    rmch_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .i_neg   (w_uop.neg),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    assign w_accn = w_uop.first ? w_mres : r_acc + w_mres;

    // hit coordinate: origin + (dir * t) >> 16, saturated to 32 bits
    assign w_hidx = 2'(w_uop.dst - rmch_pkg::D_HX);
    assign w_hsum = 121'(r_org[w_hidx]) + 121'($signed(w_accn[rmch_pkg::PROD_W-1:16]));
    always_comb begin
        if (w_hsum > 121'sd2147483647) begin
            w_hsat = 32'sh7FFFFFFF;
        end else if (w_hsum < -121'sd2147483648) begin
            w_hsat = 32'sh80000000;
        end else begin
            w_hsat = w_hsum[CW-1:0];
        end
    end

    rmch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   ({r_numt[rmch_pkg::NUMT_W-1:0], 16'd0}),
        .i_den   (r_den[rmch_pkg::DEN_W-1:0]),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    assign w_uv = (rmch_pkg::SC_W+1)'(r_numu) + (rmch_pkg::SC_W+1)'(r_numv);

    // ---- nearest vertex distance ----
    always_comb begin
        case (r_k)
            2'd0:    w_vk = r_vrd[CW-1:0];
            2'd1:    w_vk = r_vrd[2*CW-1:CW];
            default: w_vk = r_vrd[3*CW-1:2*CW];
        endcase
    end
    assign w_df  = rmch_pkg::ED_W'(w_vk) - rmch_pkg::ED_W'(r_dq[r_k]);
    assign w_dsq = w_df * w_df;
    assign w_sqn = ((r_k == 2'd0) ? '0 : r_sq) + rmch_pkg::SQ_W'(unsigned'(w_dsq));

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcnt   <= '0;
            r_tcnt   <= '0;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            // S_FIN handles the hand-off itself
            if (r_ovalid && m_axis_tready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rmch_pkg::REG_VCNT: r_vcnt <= i_cfg_data;
                    default:            r_tcnt <= i_cfg_data;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && s_axis_tuser == rmch_pkg::REQ_CAST) begin
                        r_org[0] <= s_axis_tdata[43:12];
                        r_org[1] <= s_axis_tdata[75:44];
                        r_org[2] <= s_axis_tdata[107:76];
                        r_dir[0] <= s_axis_tdata[125:108];
                        r_dir[1] <= s_axis_tdata[143:126];
                        r_dir[2] <= s_axis_tdata[161:144];
                        r_tri    <= '0;
                        r_have   <= 1'b0;
                        r_state  <= (w_nt == '0) ? S_FIN : S_TRI_RD;
                    end
                end
                S_TRI_RD: r_state <= S_TRI_WT;
                S_TRI_WT: begin
                    r_cb <= r_trd[2*rmch_pkg::IDX_W-1:rmch_pkg::IDX_W];
                    r_cc <= r_trd[3*rmch_pkg::IDX_W-1:2*rmch_pkg::IDX_W];
                    if ({1'b0, r_trd[rmch_pkg::IDX_W-1:0]} >= w_nv ||
                        {1'b0, r_trd[2*rmch_pkg::IDX_W-1:rmch_pkg::IDX_W]} >= w_nv ||
                        {1'b0, r_trd[3*rmch_pkg::IDX_W-1:2*rmch_pkg::IDX_W]} >= w_nv) begin
                        if (w_last_tri) begin
                            r_pc    <= rmch_pkg::PC_HIT0;
                            r_state <= r_have ? S_MST : S_FIN;
                        end else begin
                            r_tri   <= r_tri + rmch_pkg::CNT_W'(1);
                            r_state <= S_TRI_RD;
                        end
                    end else begin
                        r_state <= S_VB;
                    end
                end
                S_VB: begin
                    r_p0[0] <= r_vrd[CW-1:0];
                    r_p0[1] <= r_vrd[2*CW-1:CW];
                    r_p0[2] <= r_vrd[3*CW-1:2*CW];
                    r_state <= S_VC;
                end
                S_VC: begin
                    r_p1[0] <= r_vrd[CW-1:0];
                    r_p1[1] <= r_vrd[2*CW-1:CW];
                    r_p1[2] <= r_vrd[3*CW-1:2*CW];
                    r_state <= S_VD;
                end
                S_VD: begin
                    r_p2[0] <= r_vrd[CW-1:0];
                    r_p2[1] <= r_vrd[2*CW-1:CW];
                    r_p2[2] <= r_vrd[3*CW-1:2*CW];
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_ed1[k] <= rmch_pkg::ED_W'(r_p1[k]) - rmch_pkg::ED_W'(r_p0[k]);
                        r_ed2[k] <= rmch_pkg::ED_W'(r_p2[k]) - rmch_pkg::ED_W'(r_p0[k]);
                        r_rel[k] <= rmch_pkg::ED_W'(r_org[k]) - rmch_pkg::ED_W'(r_p0[k]);
                    end
                    r_pc    <= '0;
                    r_state <= S_MST;
                end
                S_MST: begin
                    r_mstart <= 1'b1;
                    r_state  <= S_MWT;
                end
                S_MWT: begin
                    if (w_mdone) begin
                        r_acc <= w_accn;
                        case (w_uop.dst)
                            rmch_pkg::D_CRA0: r_cra[0] <= rmch_pkg::CR_W'(w_accn);
                            rmch_pkg::D_CRA1: r_cra[1] <= rmch_pkg::CR_W'(w_accn);
                            rmch_pkg::D_CRA2: r_cra[2] <= rmch_pkg::CR_W'(w_accn);
                            rmch_pkg::D_CRB0: r_crb[0] <= rmch_pkg::CR_W'(w_accn);
                            rmch_pkg::D_CRB1: r_crb[1] <= rmch_pkg::CR_W'(w_accn);
                            rmch_pkg::D_CRB2: r_crb[2] <= rmch_pkg::CR_W'(w_accn);
                            rmch_pkg::D_DEN:  r_den    <= rmch_pkg::SC_W'(w_accn);
                            rmch_pkg::D_NUMU: r_numu   <= rmch_pkg::SC_W'(w_accn);
                            rmch_pkg::D_NUMV: r_numv   <= rmch_pkg::SC_W'(w_accn);
                            rmch_pkg::D_NUMT: r_numt   <= rmch_pkg::SC_W'(w_accn);
                            rmch_pkg::D_HX,
                            rmch_pkg::D_HY,
                            rmch_pkg::D_HZ:   r_dq[w_hidx] <= w_hsat;
                            default: ;
                        endcase
                        if (r_pc == rmch_pkg::PC_TRI_LAST) begin
                            r_state <= S_TEST;
                        end else if (r_pc == rmch_pkg::PC_HIT_LAST) begin
                            r_vi    <= '0;
                            r_state <= S_VS_RD;
                        end else begin
                            r_pc    <= r_pc + 5'd1;
                            r_state <= S_MST;
                        end
                    end
                end
                S_TEST: begin
                    // a zero determinant skips the triangle; else flip signs so it is positive
                    if (r_den == '0) begin
                        if (w_last_tri) begin
                            r_pc    <= rmch_pkg::PC_HIT0;
                            r_state <= r_have ? S_MST : S_FIN;
                        end else begin
                            r_tri   <= r_tri + rmch_pkg::CNT_W'(1);
                            r_state <= S_TRI_RD;
                        end
                    end else begin
                        if (r_den[rmch_pkg::SC_W-1]) begin
                            r_den  <= -r_den;
                            r_numu <= -r_numu;
                            r_numv <= -r_numv;
                            r_numt <= -r_numt;
                        end
                        r_state <= S_TEST2;
                    end
                end
                S_TEST2: begin
                    if (r_numu < 0 || r_numu > r_den || r_numv < 0 ||
                        w_uv > (rmch_pkg::SC_W+1)'(r_den) || r_numt <= 0) begin
                        if (w_last_tri) begin
                            r_pc    <= rmch_pkg::PC_HIT0;
                            r_state <= r_have ? S_MST : S_FIN;
                        end else begin
                            r_tri   <= r_tri + rmch_pkg::CNT_W'(1);
                            r_state <= S_TRI_RD;
                        end
                    end else begin
                        r_state <= S_DST;
                    end
                end
                S_DST: begin
                    r_dstart <= 1'b1;
                    r_state  <= S_DWT;
                end
                S_DWT: begin
                    if (w_ddone) begin
                        // strict compare keeps the earlier triangle on a tie
                        if (!r_have || w_quo < r_best) begin
                            r_best <= w_quo;
                            r_have <= 1'b1;
                        end
                        if (w_last_tri) begin
                            r_pc    <= rmch_pkg::PC_HIT0;
                            r_state <= S_MST;
                        end else begin
                            r_tri   <= r_tri + rmch_pkg::CNT_W'(1);
                            r_state <= S_TRI_RD;
                        end
                    end
                end
                S_VS_RD: begin
                    r_k     <= '0;
                    r_state <= S_VS_SQ;
                end
                S_VS_SQ: begin
                    r_sq <= w_sqn;
                    if (r_k == 2'd2) begin
                        r_state <= S_VS_CMP;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_VS_CMP: begin
                    if (r_vi == '0 || r_sq < r_bestsq) begin
                        r_bestsq <= r_sq;
                        r_near   <= r_vi[rmch_pkg::V_AW-1:0];
                    end
                    if ((r_vi + rmch_pkg::CNT_W'(1)) == w_nv) begin
                        r_state <= S_FIN;
                    end else begin
                        r_vi    <= r_vi + rmch_pkg::CNT_W'(1);
                        r_state <= S_VS_RD;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_ohit   <= r_have;
                        if (r_have) begin
                            r_odata[31:0]   <= r_dq[0];
                            r_odata[63:32]  <= r_dq[1];
                            r_odata[95:64]  <= r_dq[2];
                            r_odata[126:96] <= (|r_best[rmch_pkg::QUO_W-1:31]) ?
                                               31'h7FFFFFFF : r_best[30:0];
                            r_odata[139:127] <= {1'b0, r_near};
                        end else begin
                            r_odata[126:0]   <= '0;
                            r_odata[139:127] <= '1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ohit;
    assign m_axis_tdata  = {4'd0, r_odata};

endmodule
